### src/sdspi_pkg.sv
package sdspi_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_XFER  = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_INIT      = 2'd0,
    CMD_READ_ID   = 2'd1,
    CMD_READ_BLK  = 2'd2,
    CMD_WRITE_BLK = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_BUSY    = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  command;
    logic [31:0] sector;
    logic [8:0]  window_start;
    logic [9:0]  byte_count;
    logic [7:0]  rx_byte;
    logic [7:0]  load_byte;
    logic [8:0]  load_index;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_low;
    logic       slow_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [8:0] data_position;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  localparam int ID_BYTES        = 16;
  localparam int CMD_FRAME_BYTES = 6;
  localparam int CMD8_TAIL_BYTES = 4;
  localparam int CRC_BYTES       = 2;

  localparam logic [7:0]  CMD0_BYTE   = 8'h40;
  localparam logic [7:0]  CMD0_CRC    = 8'h95;
  localparam logic [7:0]  CMD8_BYTE   = 8'h48;
  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam logic [7:0]  CMD8_CRC    = 8'h87;
  localparam logic [7:0]  CMD55_BYTE  = 8'h77;
  localparam logic [7:0]  ACMD41_BYTE = 8'h69;
  localparam logic [31:0] ACMD41_ARG  = 32'h4000_0000;
  localparam logic [7:0]  ACMD41_CRC  = 8'hFF;
  localparam logic [7:0]  CMD10_BYTE  = 8'h4A;
  localparam logic [7:0]  CMD17_BYTE  = 8'h51;
  localparam logic [7:0]  CMD24_BYTE  = 8'h58;
  localparam logic [7:0]  NO_CRC      = 8'h00;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  IDLE_BYTE   = 8'hFF;
  localparam logic [7:0]  FILL_BYTE   = 8'h00;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  DRESP_MASK  = 8'h1F;
  localparam logic [7:0]  DRESP_OK    = 8'h05;

  function automatic logic [7:0] frame_byte(input logic [7:0] cmd, input logic [31:0] arg,
                                            input logic [7:0] crc, input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = cmd;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

### src/sd_spi_host_sequencer_core.sv
// SD card host sequencer for SPI mode. One input word per card byte exchange.
// Input channel (in_valid_i/in_ready_o, in_data_i): a start word picks init,
// read id, read block or write block; each following exchange word reports the
// byte received in the previous exchange; load words fill the write buffer.
// Output channel (out_valid_o/out_ready_i, out_data_o): exactly one result word
// per input word, in order, naming the next byte to send, chip select, clock
// rate, any read data byte and completion status.
// Results are registered: one input register, then the sequencer step and the
// write buffer read land in the result register. Throughput is one word per
// cycle unless the receiver stalls; the step is a single pass of logic over the
// phase register, with the buffer read registered alongside the result.
// cfg_we_i/cfg_wdata_i set the wait limit (zero waits forever); write only idle.
// Reset clears the phase to idle, selects the slow clock and empties both
// registers; write buffer contents are undefined until loaded.
// When the receiver stalls the result word holds, the input register fills,
// and in_ready_o drops until the result is taken.
module sd_spi_host_sequencer_core #(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdspi_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdspi_pkg::out_t   out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);

  localparam int SW = $clog2(BLOCK_BYTES + 1);
  localparam int AW = $clog2(BLOCK_BYTES);
  localparam int CW = ((SW > 10) ? SW : 10) + 1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD0_POLL, PH_CMD8, PH_CMD8_POLL, PH_CMD8_TAIL,
    PH_CMD55, PH_CMD55_POLL, PH_ACMD41, PH_ACMD41_GAP, PH_ACMD41_STAT,
    PH_CMD_RW, PH_R1_POLL, PH_TOKEN_POLL, PH_DATA_IN, PH_CRC_IN,
    PH_W_GAP, PH_W_TOKEN, PH_W_DATA, PH_W_CRC, PH_W_RESP, PH_W_BUSY
  } phase_e;

  typedef enum logic [1:0] {ADV_MORE, ADV_OK, ADV_TIMEOUT} adv_e;

  logic             in_vld_q;
  sdspi_pkg::in_t   in_q;
  logic             out_vld_q;
  sdspi_pkg::out_t  res_q, res_d;
  logic             use_mem_q, use_mem_d;
  logic [7:0]       rdata_q;
  logic [7:0]       mem [BLOCK_BYTES];

  phase_e           phase_q, phase_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [SW-1:0]    step_q, step_d;
  logic [31:0]      sector_q, sector_d;
  logic [8:0]       ws_q, ws_d;
  logic [9:0]       cnt_q, cnt_d;
  logic [15:0]      pc_q, pc_d;
  logic             slow_q, slow_d;
  logic [15:0]      wait_limit_q;

  logic             proc;
  logic [SW:0]      step_inc;
  logic [15:0]      pc_inc;
  logic             poll_to;
  logic [CW-1:0]    win_diff;
  logic             in_win;
  logic [CW-1:0]    load_idx;
  logic             mem_we;
  logic [AW-1:0]    waddr, raddr;
  adv_e             adv;
  logic             tx_valid;
  logic [7:0]       tx;
  logic             use_mem;
  logic [2:0]       k3;

  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;

  assign step_inc = {1'b0, step_q} + 1'b1;
  assign pc_inc   = (pc_q == 16'hFFFF) ? pc_q : pc_q + 16'd1;
  assign poll_to  = (wait_limit_q != 16'd0) && (pc_inc >= wait_limit_q);
  assign win_diff = CW'(step_q) - CW'(ws_q);
  assign in_win   = (CW'(step_q) >= CW'(ws_q)) && (win_diff < CW'(cnt_q));
  assign load_idx = CW'(in_q.load_index);
  assign waddr    = load_idx[AW-1:0];

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    step_d    = step_q;
    sector_d  = sector_q;
    ws_d      = ws_q;
    cnt_d     = cnt_q;
    pc_d      = pc_q;
    slow_d    = slow_q;
    res_d     = '0;
    mem_we    = 1'b0;
    adv       = ADV_MORE;
    tx_valid  = 1'b0;

    unique case (in_q.op)
      sdspi_pkg::OP_START: begin
        if (phase_q != PH_IDLE) begin
          res_d.status = sdspi_pkg::ST_BUSY;
        end else begin
          cmd_d    = in_q.command;
          sector_d = in_q.sector;
          ws_d     = in_q.window_start;
          cnt_d    = in_q.byte_count;
          pc_d     = '0;
          step_d   = '0;
          if (in_q.command == sdspi_pkg::CMD_INIT) begin
            slow_d  = 1'b1;
            phase_d = PH_WAKE;
          end else begin
            phase_d = PH_CMD_RW;
          end
          tx_valid = 1'b1;
        end
      end
      sdspi_pkg::OP_XFER: begin
        if (phase_q != PH_IDLE) begin
          unique case (phase_q)
            PH_WAKE: begin
              if (step_inc >= (SW+1)'(WAKE_BYTES)) begin
                phase_d = PH_CMD0;
                step_d  = '0;
              end else begin
                step_d = step_inc[SW-1:0];
              end
            end
            PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41, PH_CMD_RW: begin
              if (step_inc < (SW+1)'(sdspi_pkg::CMD_FRAME_BYTES)) begin
                step_d = step_inc[SW-1:0];
              end else begin
                step_d = '0;
                unique case (phase_q)
                  PH_CMD0: begin
                    phase_d = PH_CMD0_POLL;
                    pc_d    = '0;
                  end
                  PH_CMD8: begin
                    phase_d = PH_CMD8_POLL;
                    pc_d    = '0;
                  end
                  PH_CMD55:  phase_d = PH_CMD55_POLL;
                  PH_ACMD41: phase_d = PH_ACMD41_GAP;
                  default: begin
                    phase_d = PH_R1_POLL;
                    pc_d    = '0;
                  end
                endcase
              end
            end
            PH_CMD0_POLL: begin
              if (in_q.rx_byte == sdspi_pkg::R1_IDLE) begin
                phase_d = PH_CMD8;
                step_d  = '0;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_CMD8_POLL: begin
              if (in_q.rx_byte != sdspi_pkg::IDLE_BYTE) begin
                phase_d = PH_CMD8_TAIL;
                step_d  = '0;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_CMD8_TAIL: begin
              if (step_inc >= (SW+1)'(sdspi_pkg::CMD8_TAIL_BYTES)) begin
                phase_d = PH_CMD55;
                step_d  = '0;
                pc_d    = '0;
              end else begin
                step_d = step_inc[SW-1:0];
              end
            end
            PH_CMD55_POLL: begin
              if (in_q.rx_byte == sdspi_pkg::R1_IDLE) begin
                phase_d = PH_ACMD41;
                step_d  = '0;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_ACMD41_GAP: begin
              phase_d = PH_ACMD41_STAT;
              step_d  = '0;
            end
            PH_ACMD41_STAT: begin
              if (in_q.rx_byte == sdspi_pkg::R1_READY) begin
                slow_d = 1'b0;
                adv    = ADV_OK;
              end else begin
                // the whole cmd55/acmd41 loop shares one poll count
                pc_d = pc_inc;
                if (poll_to) begin
                  adv = ADV_TIMEOUT;
                end else begin
                  phase_d = PH_CMD55;
                  step_d  = '0;
                end
              end
            end
            PH_R1_POLL: begin
              if (in_q.rx_byte == sdspi_pkg::R1_READY) begin
                step_d = '0;
                if (cmd_q == sdspi_pkg::CMD_WRITE_BLK) begin
                  phase_d = PH_W_GAP;
                end else begin
                  phase_d = PH_TOKEN_POLL;
                  pc_d    = '0;
                end
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_TOKEN_POLL: begin
              if (in_q.rx_byte == sdspi_pkg::TOKEN_START) begin
                phase_d = PH_DATA_IN;
                step_d  = '0;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_DATA_IN: begin
              if (cmd_q == sdspi_pkg::CMD_READ_ID) begin
                res_d.data_valid    = 1'b1;
                res_d.data_byte     = in_q.rx_byte;
                res_d.data_position = 9'(step_q);
                if (step_inc >= (SW+1)'(sdspi_pkg::ID_BYTES)) begin
                  phase_d = PH_CRC_IN;
                  step_d  = '0;
                end else begin
                  step_d = step_inc[SW-1:0];
                end
              end else begin
                if (in_win) begin
                  res_d.data_valid    = 1'b1;
                  res_d.data_byte     = in_q.rx_byte;
                  res_d.data_position = 9'(win_diff);
                end
                if (step_inc >= (SW+1)'(BLOCK_BYTES)) begin
                  phase_d = PH_CRC_IN;
                  step_d  = '0;
                end else begin
                  step_d = step_inc[SW-1:0];
                end
              end
            end
            PH_CRC_IN: begin
              if (step_inc >= (SW+1)'(sdspi_pkg::CRC_BYTES)) begin
                adv = ADV_OK;
              end else begin
                step_d = step_inc[SW-1:0];
              end
            end
            PH_W_GAP: begin
              phase_d = PH_W_TOKEN;
              step_d  = '0;
            end
            PH_W_TOKEN: begin
              phase_d = PH_W_DATA;
              step_d  = '0;
            end
            PH_W_DATA: begin
              if (step_inc >= (SW+1)'(BLOCK_BYTES)) begin
                phase_d = PH_W_CRC;
                step_d  = '0;
              end else begin
                step_d = step_inc[SW-1:0];
              end
            end
            PH_W_CRC: begin
              if (step_inc >= (SW+1)'(sdspi_pkg::CRC_BYTES)) begin
                phase_d = PH_W_RESP;
                step_d  = '0;
                pc_d    = '0;
              end else begin
                step_d = step_inc[SW-1:0];
              end
            end
            PH_W_RESP: begin
              if ((in_q.rx_byte & sdspi_pkg::DRESP_MASK) == sdspi_pkg::DRESP_OK) begin
                phase_d = PH_W_BUSY;
                step_d  = '0;
                pc_d    = '0;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            PH_W_BUSY: begin
              if (in_q.rx_byte != 8'h00) begin
                adv = ADV_OK;
              end else begin
                pc_d = pc_inc;
                if (poll_to) adv = ADV_TIMEOUT;
              end
            end
            default: adv = ADV_OK;
          endcase

          if (adv == ADV_MORE) begin
            tx_valid = 1'b1;
          end else begin
            res_d.done_res = 1'b1;
            res_d.status   = (adv == ADV_TIMEOUT) ? sdspi_pkg::ST_TIMEOUT : sdspi_pkg::ST_OK;
            phase_d        = PH_IDLE;
            step_d         = '0;
          end
        end
      end
      sdspi_pkg::OP_LOAD: begin
        mem_we = (load_idx < CW'(BLOCK_BYTES));
      end
      default: ;
    endcase
  end

  // next byte to send, taken from the updated phase and step
  assign k3    = step_d[2:0];
  assign raddr = step_d[AW-1:0];

  always_comb begin
    tx      = sdspi_pkg::IDLE_BYTE;
    use_mem = 1'b0;
    unique case (phase_d)
      PH_CMD0:
        tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD0_BYTE, 32'd0, sdspi_pkg::CMD0_CRC, k3);
      PH_CMD8:
        tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD8_BYTE, sdspi_pkg::CMD8_ARG,
                                   sdspi_pkg::CMD8_CRC, k3);
      PH_CMD55:
        tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD55_BYTE, 32'd0, sdspi_pkg::NO_CRC, k3);
      PH_ACMD41:
        tx = sdspi_pkg::frame_byte(sdspi_pkg::ACMD41_BYTE, sdspi_pkg::ACMD41_ARG,
                                   sdspi_pkg::ACMD41_CRC, k3);
      PH_CMD_RW: begin
        if (cmd_d == sdspi_pkg::CMD_READ_ID) begin
          tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD10_BYTE, 32'd0, sdspi_pkg::NO_CRC, k3);
        end else if (cmd_d == sdspi_pkg::CMD_READ_BLK) begin
          tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD17_BYTE, sector_d, sdspi_pkg::NO_CRC, k3);
        end else begin
          tx = sdspi_pkg::frame_byte(sdspi_pkg::CMD24_BYTE, sector_d, sdspi_pkg::NO_CRC, k3);
        end
      end
      PH_W_TOKEN: tx = sdspi_pkg::TOKEN_START;
      PH_W_DATA: begin
        // zero padding past the byte count, buffer byte otherwise
        tx      = sdspi_pkg::FILL_BYTE;
        use_mem = (CW'(step_d) < CW'(cnt_d));
      end
      PH_W_CRC: tx = sdspi_pkg::NO_CRC;
      default:  tx = sdspi_pkg::IDLE_BYTE;
    endcase
  end

  always_comb begin
    res_d_fill();
  end

  function automatic void res_d_fill();
  endfunction

  assign use_mem_d = tx_valid && use_mem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      phase_q      <= PH_IDLE;
      cmd_q        <= '0;
      step_q       <= '0;
      sector_q     <= '0;
      ws_q         <= '0;
      cnt_q        <= '0;
      pc_q         <= '0;
      slow_q       <= 1'b1;
      wait_limit_q <= '0;
      use_mem_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (proc) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (proc) begin
        phase_q   <= phase_d;
        cmd_q     <= cmd_d;
        step_q    <= step_d;
        sector_q  <= sector_d;
        ws_q      <= ws_d;
        cnt_q     <= cnt_d;
        pc_q      <= pc_d;
        slow_q    <= slow_d;
        use_mem_q <= use_mem_d;
      end
      if (cfg_we_i) begin
        wait_limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (proc) begin
      res_q            <= res_d;
      res_q.tx_valid   <= tx_valid;
      res_q.tx_byte    <= tx_valid ? tx : 8'h00;
      res_q.select_low <= tx_valid && (phase_d != PH_WAKE);
      res_q.slow_clock <= slow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && mem_we) begin
      mem[waddr] <= in_q.load_byte;
    end
    if (proc && use_mem_d) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_valid_o = out_vld_q;

  always_comb begin
    out_data_o = res_q;
    if (use_mem_q) begin
      out_data_o.tx_byte = rdata_q;
    end
  end

endmodule

### src/sdspi_checker.sv
module sdspi_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input sdspi_pkg::out_t out_data_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  // a finished sequence releases chip select and asks for no exchange
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.done_res |-> !out_data_i.tx_valid && !out_data_i.select_low)
    else $error("done word still requests an exchange");

  // an ignored start neither finishes nor exchanges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == sdspi_pkg::ST_BUSY)
      |-> !out_data_i.tx_valid && !out_data_i.done_res)
    else $error("busy status with activity");

  // read data only arrives mid-transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.data_valid |-> out_data_i.tx_valid && !out_data_i.done_res)
    else $error("read byte outside a transfer");

  // no exchange means a quiet tx byte and chip select
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.tx_valid
      |-> (out_data_i.tx_byte == 8'h00) && !out_data_i.select_low)
    else $error("tx fields set without an exchange");

endmodule

bind sd_spi_host_sequencer_core sdspi_checker u_sdspi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sdspi_pkg::*;

  localparam int BLK         = 512;
  localparam int WAKE        = 10;
  localparam int LATENCY     = 2;
  localparam int PHASE_WORDS = 160;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_WAKE, SQ_CMD0, SQ_CMD0_POLL, SQ_CMD8, SQ_CMD8_POLL, SQ_CMD8_TAIL,
    SQ_CMD55, SQ_CMD55_POLL, SQ_ACMD41, SQ_ACMD41_GAP, SQ_ACMD41_STAT,
    SQ_CMD_RW, SQ_R1_POLL, SQ_TOKEN_POLL, SQ_DATA_IN, SQ_CRC_IN,
    SQ_W_GAP, SQ_W_TOKEN, SQ_W_DATA, SQ_W_CRC, SQ_W_RESP, SQ_W_BUSY
  } seq_phase_e;

  typedef enum logic [1:0] {ADV_MORE, ADV_DONE, ADV_TIMEOUT} adv_e;

  typedef struct packed {
    in_t  word;
    logic typed;
    out_t result;
  } vec_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  sd_spi_host_sequencer_core #(
    .BLOCK_BYTES(BLK),
    .WAKE_BYTES (WAKE)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // sequencer image kept by the testbench
  seq_phase_e  sq_phase;
  command_e    sq_cmd;
  int          sq_step;
  logic [31:0] sq_sector;
  int          sq_wstart;
  int          sq_count;
  int          sq_polls;
  logic        sq_slow;
  logic [15:0] wait_limit_q;
  logic [7:0]  wbuf [BLK];
  bit          wbuf_loaded [BLK];
  bit          rd_valid;
  logic [7:0]  rd_byte;
  int          rd_pos;

  out_t expected_q [$];
  int   n_errors   = 0;
  int   n_results  = 0;
  int   cycles     = 0;
  int   stim_words = 0;
  int   src_idle   = 0;
  int   sink_stall = 0;

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic void enter(input seq_phase_e p, input bit new_wait);
    sq_phase = p;
    sq_step  = 0;
    if (new_wait) sq_polls = 0;
  endfunction

  function automatic logic [7:0] frame_at(input logic [7:0] code, input logic [31:0] arg,
                                          input logic [7:0] crc, input int k);
    if (k == 0) return code;
    if (k >= CMD_FRAME_BYTES - 1) return crc;
    return arg[8 * (4 - k) +: 8];
  endfunction

  function automatic logic [7:0] next_tx_byte();
    case (sq_phase)
      SQ_CMD0:   return frame_at(CMD0_BYTE, 32'h0, CMD0_CRC, sq_step);
      SQ_CMD8:   return frame_at(CMD8_BYTE, CMD8_ARG, CMD8_CRC, sq_step);
      SQ_CMD55:  return frame_at(CMD55_BYTE, 32'h0, NO_CRC, sq_step);
      SQ_ACMD41: return frame_at(ACMD41_BYTE, ACMD41_ARG, ACMD41_CRC, sq_step);
      SQ_CMD_RW: begin
        if (sq_cmd == CMD_READ_ID) return frame_at(CMD10_BYTE, 32'h0, NO_CRC, sq_step);
        if (sq_cmd == CMD_READ_BLK) return frame_at(CMD17_BYTE, sq_sector, NO_CRC, sq_step);
        return frame_at(CMD24_BYTE, sq_sector, NO_CRC, sq_step);
      end
      SQ_W_TOKEN: return TOKEN_START;
      SQ_W_DATA: begin
        if (sq_step < sq_count && sq_step < BLK) return wbuf[sq_step];
        return FILL_BYTE;
      end
      SQ_W_CRC: return NO_CRC;
      default:  return IDLE_BYTE;
    endcase
  endfunction

  function automatic adv_e poll_miss();
    if (sq_polls < 65535) sq_polls++;
    if (wait_limit_q != 0 && sq_polls >= wait_limit_q) return ADV_TIMEOUT;
    return ADV_MORE;
  endfunction

  function automatic adv_e advance(input logic [7:0] rx);
    int span;
    case (sq_phase)
      SQ_WAKE: begin
        sq_step++;
        if (sq_step >= WAKE) enter(SQ_CMD0, 1'b0);
        return ADV_MORE;
      end
      SQ_CMD0, SQ_CMD8, SQ_CMD55, SQ_ACMD41, SQ_CMD_RW: begin
        sq_step++;
        if (sq_step < CMD_FRAME_BYTES) return ADV_MORE;
        case (sq_phase)
          SQ_CMD0:   enter(SQ_CMD0_POLL, 1'b1);
          SQ_CMD8:   enter(SQ_CMD8_POLL, 1'b1);
          SQ_CMD55:  enter(SQ_CMD55_POLL, 1'b0);
          SQ_ACMD41: enter(SQ_ACMD41_GAP, 1'b0);
          default:   enter(SQ_R1_POLL, 1'b1);
        endcase
        return ADV_MORE;
      end
      SQ_CMD0_POLL: begin
        if (rx == R1_IDLE) begin
          enter(SQ_CMD8, 1'b0);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_CMD8_POLL: begin
        if (rx != IDLE_BYTE) begin
          enter(SQ_CMD8_TAIL, 1'b0);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_CMD8_TAIL: begin
        sq_step++;
        if (sq_step >= CMD8_TAIL_BYTES) enter(SQ_CMD55, 1'b1);
        return ADV_MORE;
      end
      SQ_CMD55_POLL: begin
        if (rx == R1_IDLE) begin
          enter(SQ_ACMD41, 1'b0);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_ACMD41_GAP: begin
        enter(SQ_ACMD41_STAT, 1'b0);
        return ADV_MORE;
      end
      SQ_ACMD41_STAT: begin
        if (rx == R1_READY) begin
          sq_slow = 1'b0;
          return ADV_DONE;
        end
        // the whole cmd55/acmd41 loop shares one poll budget
        if (poll_miss() == ADV_TIMEOUT) return ADV_TIMEOUT;
        enter(SQ_CMD55, 1'b0);
        return ADV_MORE;
      end
      SQ_R1_POLL: begin
        if (rx == R1_READY) begin
          if (sq_cmd == CMD_WRITE_BLK) enter(SQ_W_GAP, 1'b0);
          else enter(SQ_TOKEN_POLL, 1'b1);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_TOKEN_POLL: begin
        if (rx == TOKEN_START) begin
          enter(SQ_DATA_IN, 1'b0);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_DATA_IN: begin
        if (sq_cmd == CMD_READ_ID) begin
          rd_valid = 1'b1;
          rd_byte  = rx;
          rd_pos   = sq_step;
          span     = ID_BYTES;
        end else begin
          if (sq_step >= sq_wstart && sq_step - sq_wstart < sq_count) begin
            rd_valid = 1'b1;
            rd_byte  = rx;
            rd_pos   = sq_step - sq_wstart;
          end
          span = BLK;
        end
        sq_step++;
        if (sq_step >= span) enter(SQ_CRC_IN, 1'b0);
        return ADV_MORE;
      end
      SQ_CRC_IN: begin
        sq_step++;
        if (sq_step >= CRC_BYTES) return ADV_DONE;
        return ADV_MORE;
      end
      SQ_W_GAP: begin
        enter(SQ_W_TOKEN, 1'b0);
        return ADV_MORE;
      end
      SQ_W_TOKEN: begin
        enter(SQ_W_DATA, 1'b0);
        return ADV_MORE;
      end
      SQ_W_DATA: begin
        sq_step++;
        if (sq_step >= BLK) enter(SQ_W_CRC, 1'b0);
        return ADV_MORE;
      end
      SQ_W_CRC: begin
        sq_step++;
        if (sq_step >= CRC_BYTES) enter(SQ_W_RESP, 1'b1);
        return ADV_MORE;
      end
      SQ_W_RESP: begin
        if ((rx & DRESP_MASK) == DRESP_OK) begin
          enter(SQ_W_BUSY, 1'b1);
          return ADV_MORE;
        end
        return poll_miss();
      end
      SQ_W_BUSY: begin
        // card holds the line at zero while busy
        if (rx != 8'h00) return ADV_DONE;
        return poll_miss();
      end
      default: return ADV_DONE;
    endcase
  endfunction

  function automatic out_t predict(input in_t w);
    out_t r;
    adv_e a;
    r        = '0;
    rd_valid = 1'b0;
    rd_byte  = '0;
    rd_pos   = 0;
    case (w.op)
      OP_START: begin
        if (sq_phase != SQ_IDLE) begin
          r.status = ST_BUSY;
        end else begin
          sq_cmd    = command_e'(w.command);
          sq_sector = w.sector;
          sq_wstart = w.window_start;
          sq_count  = w.byte_count;
          sq_polls  = 0;
          if (sq_cmd == CMD_INIT) begin
            sq_slow = 1'b1;
            enter(SQ_WAKE, 1'b1);
          end else begin
            enter(SQ_CMD_RW, 1'b1);
          end
          r.tx_valid = 1'b1;
        end
      end
      OP_XFER: begin
        if (sq_phase != SQ_IDLE) begin
          a = advance(w.rx_byte);
          if (a == ADV_MORE) begin
            r.tx_valid = 1'b1;
          end else begin
            r.done_res = 1'b1;
            r.status   = (a == ADV_TIMEOUT) ? ST_TIMEOUT : ST_OK;
            enter(SQ_IDLE, 1'b0);
          end
        end
      end
      OP_LOAD: begin
        wbuf[w.load_index]        = w.load_byte;
        wbuf_loaded[w.load_index] = 1'b1;
      end
      default: ;
    endcase
    if (r.tx_valid) begin
      r.tx_byte    = next_tx_byte();
      r.select_low = (sq_phase != SQ_WAKE);
    end
    r.slow_clock    = sq_slow;
    r.data_valid    = rd_valid;
    r.data_byte     = rd_byte;
    r.data_position = rd_pos;
    return r;
  endfunction

  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < BLK && wbuf_loaded[n]) n++;
    return n;
  endfunction

  function automatic in_t random_word();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  // random card answers for the poll the sequencer is in, often forced to the byte that poll tests
  function automatic logic [7:0] card_reply();
    logic [7:0] b;
    b = $urandom;
    case (sq_phase)
      SQ_CMD0_POLL:   if (chance(40)) b = R1_IDLE;
      SQ_CMD8_POLL:   if (chance(50)) b = IDLE_BYTE;
      SQ_CMD55_POLL:  if (chance(55)) b = R1_IDLE;
      SQ_ACMD41_STAT: if (chance(35)) b = R1_READY;
      SQ_R1_POLL:     if (chance(55)) b = R1_READY;
      SQ_TOKEN_POLL:  if (chance(45)) b = TOKEN_START;
      SQ_W_RESP:      if (chance(55)) b = (b & ~DRESP_MASK) | DRESP_OK;
      SQ_W_BUSY:      if (chance(50)) b = 8'h00;
      default: ;
    endcase
    return b;
  endfunction

  function automatic out_t outcome(input bit txv, input logic [7:0] txb, input bit sel,
                                   input bit done, input status_e st);
    out_t r;
    r            = '0;
    r.tx_valid   = txv;
    r.tx_byte    = txb;
    r.select_low = sel;
    r.slow_clock = 1'b1;
    r.done_res   = done;
    r.status     = st;
    return r;
  endfunction

  function automatic vec_t row(input op_e op, input command_e cmd, input logic [31:0] sector,
                               input logic [8:0] first, input logic [9:0] count,
                               input logic [7:0] rx, input logic [7:0] lb,
                               input logic [8:0] li, input bit typed, input out_t want);
    vec_t v;
    v.word.op           = op;
    v.word.command      = cmd;
    v.word.sector       = sector;
    v.word.window_start = first;
    v.word.byte_count   = count;
    v.word.rx_byte      = rx;
    v.word.load_byte    = lb;
    v.word.load_index   = li;
    v.typed             = typed;
    v.result            = want;
    return v;
  endfunction

  function automatic vec_t xfer(input logic [7:0] rx);
    return row(OP_XFER, CMD_INIT, 32'h0, 9'd0, 10'd0, rx, 8'h00, 9'd0, 1'b0, '0);
  endfunction

  task automatic report(input string what, input int got, input int want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch in result %0d, %0s: got 'h%0h, want 'h%0h",
               n_results, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report(what, got, want);
  endtask

  task automatic send_word(input in_t w, input bit typed, input out_t want);
    out_t guess;
    if (!(w.op == OP_NONE || (w.op == OP_XFER && sq_phase == SQ_IDLE) ||
          (w.op == OP_START && sq_phase != SQ_IDLE)))
      stim_words++;
    guess = predict(w);
    expected_q.push_back(typed ? want : guess);
    while (chance(src_idle)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic set_wait_limit(input logic [15:0] v);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= v;
    wait_limit_q  = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_buffer(input int n);
    in_t w;
    int  first;
    first = loaded_prefix();
    for (int i = 0; i < n && first + i < BLK; i++) begin
      w            = random_word();
      w.op         = OP_LOAD;
      w.load_index = first + i;
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic start_command(input command_e c, input int forced_count);
    in_t w;
    int  p;
    w         = random_word();
    w.op      = OP_START;
    w.command = c;
    if (chance(30)) w.window_start = $urandom_range(BLK - 32, BLK - 1);
    if (c == CMD_READ_BLK) begin
      case ($urandom_range(0, 2))
        0:       w.byte_count = $urandom_range(0, 24);
        1:       w.byte_count = $urandom_range(0, 1023);
        default: w.byte_count = BLK;
      endcase
    end else if (c == CMD_WRITE_BLK) begin
      // never let a write send a buffer entry that was not loaded
      p = loaded_prefix();
      if (forced_count >= 0 && p == BLK) w.byte_count = forced_count;
      else if (p == BLK) w.byte_count = $urandom_range(0, 1023);
      else w.byte_count = $urandom_range(0, p);
    end
    send_word(w, 1'b0, '0);
  endtask

  task automatic busy_step();
    in_t w;
    w = random_word();
    case ($urandom_range(0, 49))
      0:       w.op = OP_START;
      1:       w.op = OP_NONE;
      2, 3:    w.op = OP_LOAD;
      default: begin
        w.op      = OP_XFER;
        w.rx_byte = card_reply();
      end
    endcase
    send_word(w, 1'b0, '0);
  endtask

  task automatic finish_sequence();
    while (sq_phase != SQ_IDLE) busy_step();
  endtask

  task automatic idle_step();
    in_t w;
    int  r;
    r = $urandom_range(0, 19);
    if (r < 2) begin
      w    = random_word();
      w.op = (r == 0) ? OP_XFER : OP_NONE;
      send_word(w, 1'b0, '0);
    end else if (r < 5) begin
      fill_buffer(chance(15) ? BLK : $urandom_range(1, 40));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) start_command(CMD_INIT, -1);
      else if (r < 55) start_command(CMD_READ_ID, -1);
      else if (r < 75) start_command(CMD_READ_BLK, -1);
      else start_command(CMD_WRITE_BLK, -1);
    end
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= sink_stall);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("result word with nothing pending", out_data_o, 0);
      end else begin
        want = expected_q.pop_front();
        check_field("tx_valid", out_data_o.tx_valid, want.tx_valid);
        check_field("tx_byte", out_data_o.tx_byte, want.tx_byte);
        check_field("select_low", out_data_o.select_low, want.select_low);
        check_field("slow_clock", out_data_o.slow_clock, want.slow_clock);
        check_field("data_valid", out_data_o.data_valid, want.data_valid);
        check_field("data_byte", out_data_o.data_byte, want.data_byte);
        check_field("data_position", out_data_o.data_position, want.data_position);
        check_field("done_res", out_data_o.done_res, want.done_res);
        check_field("status", out_data_o.status, want.status);
      end
      n_results++;
    end
  end

  initial begin : stimulus
    vec_t directed [24];
    int   base;

    sq_phase     = SQ_IDLE;
    sq_cmd       = CMD_INIT;
    sq_step      = 0;
    sq_sector    = '0;
    sq_wstart    = 0;
    sq_count     = 0;
    sq_polls     = 0;
    sq_slow      = 1'b1;
    wait_limit_q = '0;
    foreach (wbuf_loaded[i]) wbuf_loaded[i] = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_wait_limit(16'd1);

    directed = '{
      row(OP_XFER, CMD_INIT, 32'h0, 9'd0, 10'd0, 8'hFF, 8'h00, 9'd0,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b0, ST_OK)),
      row(OP_NONE, CMD_WRITE_BLK, 32'hFFFF_FFFF, 9'd511, 10'd1023, 8'h00, 8'hFF, 9'd511,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b0, ST_OK)),
      row(OP_LOAD, CMD_INIT, 32'h0, 9'd0, 10'd0, 8'hFF, 8'h00, 9'd0,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b0, ST_OK)),
      row(OP_LOAD, CMD_INIT, 32'h0, 9'd0, 10'd0, 8'h00, 8'hFF, 9'd511,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b0, ST_OK)),
      row(OP_START, CMD_READ_BLK, 32'hFFFF_FFFF, 9'd511, 10'd1023, 8'h00, 8'h00, 9'd0,
          1'b1, outcome(1'b1, CMD17_BYTE, 1'b1, 1'b0, ST_OK)),
      // start while busy is dropped
      row(OP_START, CMD_INIT, 32'h0, 9'd0, 10'd0, 8'h00, 8'h00, 9'd0,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b0, ST_BUSY)),
      xfer(8'h00), xfer(8'hFF), xfer(8'h5A), xfer(8'hA5), xfer(8'h01), xfer(8'hFE),
      // with a limit of one the first bad r1 poll ends the read
      row(OP_XFER, CMD_INIT, 32'h0, 9'd0, 10'd0, 8'hFF, 8'h00, 9'd0,
          1'b1, outcome(1'b0, 8'h00, 1'b0, 1'b1, ST_TIMEOUT)),
      row(OP_START, CMD_INIT, 32'h1234_5678, 9'd0, 10'd0, 8'h00, 8'h00, 9'd0,
          1'b1, outcome(1'b1, IDLE_BYTE, 1'b0, 1'b0, ST_OK)),
      xfer(8'h00), xfer(8'hFF), xfer(8'h00), xfer(8'hFF), xfer(8'h00),
      xfer(8'hFF), xfer(8'h00), xfer(8'hFF), xfer(8'h00), xfer(8'hFF)
    };
    foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].result);

    for (int ph = 0; ph < 4; ph++) begin
      base = stim_words;
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin
            src_idle   = 46;
            sink_stall = 0;
            set_wait_limit(16'd0);
            start_command(CMD_INIT, -1);
            finish_sequence();
            start_command(CMD_READ_BLK, -1);
            finish_sequence();
          end
          2: begin
            src_idle   = 0;
            sink_stall = 46;
            set_wait_limit(16'hFFFF);
            fill_buffer(BLK);
            start_command(CMD_WRITE_BLK, $urandom_range(BLK + 1, 1023));
            finish_sequence();
          end
          default: begin
            src_idle   = 25;
            sink_stall = 25;
            set_wait_limit($urandom_range(2, 6));
            start_command(CMD_READ_ID, -1);
            finish_sequence();
          end
        endcase
      end
      while (stim_words - base < PHASE_WORDS || sq_phase != SQ_IDLE) begin
        if (sq_phase == SQ_IDLE) idle_step();
        else busy_step();
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
